// ===== rtl/core/mwt_pkg.sv =====
// Shared types and codes for the mission waypoint transfer block.
`timescale 1ns / 1ps
package mwt_pkg;
    localparam logic [2:0] CMD_LIST   = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_UPLOAD = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] K_COUNT      = 3'd0;
    localparam logic [2:0] K_ITEM       = 3'd1;
    localparam logic [2:0] K_REQ_INT    = 3'd2;
    localparam logic [2:0] K_REQ_LEGACY = 3'd3;
    localparam logic [2:0] K_ACK        = 3'd4;

    localparam logic [1:0] A_ACCEPTED = 2'd0;
    localparam logic [1:0] A_ERROR    = 2'd1;
    localparam logic [1:0] A_BADSEQ   = 2'd2;

    // Classified word passed from front to back
    typedef struct packed {
        logic        valid;
        logic [2:0]  cmd;
        logic [15:0] seq;
        logic [15:0] count;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic        legacy;
    } t_word;
endpackage

// ===== rtl/core/mwt_front.sv =====
// Front end: accepts command words into a one-entry queue.
`timescale 1ns / 1ps
module mwt_front import mwt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_word       i_word,
    input  logic        i_pop,
    output logic        o_busy,
    output t_word       o_word
);
    t_word r_q;

    assign o_busy = r_q.valid;
    assign o_word = r_q;

    // Hold one word until the back end takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_start && !r_q.valid) begin
            r_q <= i_word;
            r_q.valid <= (i_word.cmd <= CMD_CLEAR);
        end else if (i_pop) begin
            r_q.valid <= 1'b0;
        end
    end
endmodule

// ===== rtl/core/mwt_back.sv =====
// Back end: protocol state, waypoint tables and result sequencing.
`timescale 1ns / 1ps
module mwt_back import mwt_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_word              i_word,
    output logic               o_pop,
    output logic               o_valid,
    output logic [2:0]         o_reply_kind,
    output logic [1:0]         o_ack_code,
    output logic [15:0]        o_reply_number,
    output logic signed [31:0] o_reply_lat,
    output logic signed [31:0] o_reply_lon,
    output logic signed [31:0] o_reply_alt,
    output logic               o_upload_done,
    output logic               o_last
);
    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [16:0] MAXW = 17'(MAX_WAYPOINTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_ACK  = 2'd2;

    logic [31:0] r_lat [MAX_WAYPOINTS];
    logic [31:0] r_lon [MAX_WAYPOINTS];
    logic [31:0] r_alt [MAX_WAYPOINTS];
    logic [31:0] r_rd_lat, r_rd_lon, r_rd_alt;

    logic [1:0]    r_state;
    logic          r_receiving;
    logic [CW-1:0] r_expected, r_next, r_stored;
    logic [15:0]   r_rd_seq;
    logic          r_rd_ack;

    logic        r_v, r_last, r_done;
    logic [2:0]  r_kind;
    logic [1:0]  r_code;
    logic [15:0] r_num;
    logic        r_item;

    logic [AW-1:0] w_addr;
    logic          w_seq_ok, w_read_ok;
    logic [CW:0]   w_next1;

    assign w_addr    = i_word.seq[AW-1:0];
    assign w_seq_ok  = ({1'b0, i_word.seq} < MAXW) &&
                       (i_word.seq == 16'(r_next));
    assign w_read_ok = ({1'b0, i_word.seq} < MAXW) &&
                       (i_word.seq < 16'(r_stored));
    assign w_next1   = {1'b0, r_next} + 1'b1;
    assign o_pop     = i_word.valid && (r_state == S_IDLE);

    // Table ports: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (o_pop && i_word.cmd == CMD_UPLOAD && r_receiving && w_seq_ok) begin
            r_lat[w_addr] <= i_word.lat;
            r_lon[w_addr] <= i_word.lon;
            r_alt[w_addr] <= i_word.alt;
        end
        r_rd_lat <= r_lat[w_addr];
        r_rd_lon <= r_lon[w_addr];
        r_rd_alt <= r_alt[w_addr];
    end

    // Protocol sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_receiving <= 1'b0;
            r_expected  <= '0;
            r_next      <= '0;
            r_stored    <= '0;
            r_v         <= 1'b0;
            r_item      <= 1'b0;
        end else begin
            r_v    <= 1'b0;
            r_item <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_kind <= K_ACK;
                        r_code <= A_ACCEPTED;
                        r_num  <= '0;
                        r_done <= 1'b0;
                        r_last <= 1'b1;
                        case (i_word.cmd)
                            CMD_LIST: begin
                                r_v    <= 1'b1;
                                r_kind <= K_COUNT;
                                r_num  <= 16'(r_stored);
                            end
                            CMD_READ: begin
                                if (w_read_ok) begin
                                    r_state  <= S_READ;
                                    r_rd_seq <= i_word.seq;
                                    r_rd_ack <= (17'(i_word.seq) + 17'd1 ==
                                                 17'(r_stored));
                                end
                            end
                            CMD_START: begin
                                r_v <= 1'b1;
                                if ({1'b0, i_word.count} > MAXW) begin
                                    r_code <= A_ERROR;
                                end else if (i_word.count == 16'd0) begin
                                    r_expected  <= '0;
                                    r_next      <= '0;
                                    r_stored    <= '0;
                                    r_receiving <= 1'b0;
                                    r_done      <= 1'b1;
                                end else begin
                                    r_expected  <= CW'(i_word.count);
                                    r_next      <= '0;
                                    r_receiving <= 1'b1;
                                    r_kind      <= K_REQ_INT;
                                end
                            end
                            CMD_UPLOAD: begin
                                if (r_receiving) begin
                                    r_v <= 1'b1;
                                    if (!w_seq_ok) begin
                                        r_receiving <= 1'b0;
                                        r_code      <= A_BADSEQ;
                                    end else begin
                                        r_next <= CW'(w_next1);
                                        if (w_next1 < {1'b0, r_expected}) begin
                                            r_kind <= i_word.legacy ? K_REQ_LEGACY
                                                                    : K_REQ_INT;
                                            r_num  <= 16'(w_next1);
                                        end else begin
                                            r_stored    <= r_expected;
                                            r_receiving <= 1'b0;
                                            r_done      <= 1'b1;
                                        end
                                    end
                                end
                            end
                            CMD_CLEAR: begin
                                r_v      <= 1'b1;
                                r_stored <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_v    <= 1'b1;
                    r_item <= 1'b1;
                    r_kind <= K_ITEM;
                    r_code <= A_ACCEPTED;
                    r_num  <= r_rd_seq;
                    r_done <= 1'b0;
                    r_last <= !r_rd_ack;
                    r_state <= r_rd_ack ? S_ACK : S_IDLE;
                end
                S_ACK: begin
                    r_v     <= 1'b1;
                    r_kind  <= K_ACK;
                    r_code  <= A_ACCEPTED;
                    r_num   <= '0;
                    r_done  <= 1'b0;
                    r_last  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item data only on item replies
    logic [31:0] r_olat, r_olon, r_oalt;
    always_ff @(posedge i_clk) begin
        r_olat <= (r_state == S_READ) ? r_rd_lat : '0;
        r_olon <= (r_state == S_READ) ? r_rd_lon : '0;
        r_oalt <= (r_state == S_READ) ? r_rd_alt : '0;
    end

    assign o_valid        = r_v;
    assign o_reply_kind   = r_kind;
    assign o_ack_code     = r_code;
    assign o_reply_number = r_num;
    assign o_reply_lat    = r_item ? r_olat : '0;
    assign o_reply_lon    = r_item ? r_olon : '0;
    assign o_reply_alt    = r_item ? r_oalt : '0;
    assign o_upload_done  = r_done;
    assign o_last         = r_last;
endmodule

// ===== rtl/core/mission_waypoint_transfer.sv =====
// Top level of the mission waypoint transfer block.
`timescale 1ns / 1ps
// A result passes the front queue and then the result register; an item read
// gives its item reply after the read state and, for the final item, the ack
// in the next cycle. Busy stays high while a word waits in the front queue;
// a read of the final item keeps the next word there until its ack is sent.
// Reset: synchronous active low, clears protocol state; tables are not cleared.
// The receiver cannot stall; each result shows for one cycle with o_valid.
module mission_waypoint_transfer import mwt_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic [15:0]        i_seq,
    input  logic [15:0]        i_count,
    input  logic signed [31:0] i_lat_e7,
    input  logic signed [31:0] i_lon_e7,
    input  logic signed [31:0] i_alt_cm,
    input  logic               i_legacy_form,
    output logic               o_valid,
    output logic [2:0]         o_reply_kind,
    output logic [1:0]         o_ack_code,
    output logic [15:0]        o_reply_number,
    output logic signed [31:0] o_reply_lat,
    output logic signed [31:0] o_reply_lon,
    output logic signed [31:0] o_reply_alt,
    output logic               o_upload_done,
    output logic               o_last
);
    t_word w_in, w_q;
    logic  w_pop;

    assign w_in = '{valid: 1'b1, cmd: i_cmd, seq: i_seq, count: i_count,
                    lat: i_lat_e7, lon: i_lon_e7, alt: i_alt_cm,
                    legacy: i_legacy_form};

    mwt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_word(w_in),
        .i_pop(w_pop), .o_busy(busy), .o_word(w_q)
    );

    mwt_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(w_q), .o_pop(w_pop),
        .o_valid(o_valid), .o_reply_kind(o_reply_kind), .o_ack_code(o_ack_code),
        .o_reply_number(o_reply_number), .o_reply_lat(o_reply_lat),
        .o_reply_lon(o_reply_lon), .o_reply_alt(o_reply_alt),
        .o_upload_done(o_upload_done), .o_last(o_last)
    );
endmodule

// ===== test/mission_waypoint_transfer_check.sv =====
// Checker for the mission waypoint transfer block: predicts replies and compares them.
`timescale 1ns / 1ps
module mission_waypoint_transfer_check import mwt_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic [15:0]        i_seq,
    input  logic [15:0]        i_count,
    input  logic signed [31:0] i_lat_e7,
    input  logic signed [31:0] i_lon_e7,
    input  logic signed [31:0] i_alt_cm,
    input  logic               i_legacy_form,
    input  logic               o_valid,
    input  logic [2:0]         o_reply_kind,
    input  logic [1:0]         o_ack_code,
    input  logic [15:0]        o_reply_number,
    input  logic signed [31:0] o_reply_lat,
    input  logic signed [31:0] o_reply_lon,
    input  logic signed [31:0] o_reply_alt,
    input  logic               o_upload_done,
    input  logic               o_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_reply_total
);
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  code;
        logic [15:0] number;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic        done;
        logic        last;
    } t_reply;

    t_reply      reply_q[$];
    logic        receiving;
    logic [15:0] expected_items;
    logic [15:0] next_upload;
    logic [15:0] stored_items;
    logic [31:0] lat_tab[MAX_WAYPOINTS];
    logic [31:0] lon_tab[MAX_WAYPOINTS];
    logic [31:0] alt_tab[MAX_WAYPOINTS];

    assign o_pending = reply_q.size();

    function automatic t_reply make_reply(logic [2:0] kind, logic [1:0] code,
                                          logic [15:0] number, logic [31:0] lat,
                                          logic [31:0] lon, logic [31:0] alt,
                                          logic done);
        t_reply r;
        r = '{kind, code, number, lat, lon, alt, done, 1'b0};
        return r;
    endfunction

    // Apply one accepted word to the shadow state, queue expected replies
    task automatic predict_word();
        t_reply out[$];
        int     s;
        s = i_seq;
        case (i_cmd)
            CMD_LIST: out.push_back(make_reply(K_COUNT, A_ACCEPTED, stored_items,
                                               0, 0, 0, 0));
            CMD_READ: begin
                if (s < stored_items && s < MAX_WAYPOINTS) begin
                    out.push_back(make_reply(K_ITEM, A_ACCEPTED, i_seq, lat_tab[s],
                                             lon_tab[s], alt_tab[s], 0));
                    if (s + 1 == stored_items)
                        out.push_back(make_reply(K_ACK, A_ACCEPTED, 0, 0, 0, 0, 0));
                end
            end
            CMD_START: begin
                if (i_count > MAX_WAYPOINTS) begin
                    out.push_back(make_reply(K_ACK, A_ERROR, 0, 0, 0, 0, 0));
                end else if (i_count == 0) begin
                    expected_items = 0;
                    next_upload    = 0;
                    stored_items   = 0;
                    receiving      = 0;
                    out.push_back(make_reply(K_ACK, A_ACCEPTED, 0, 0, 0, 0, 1));
                end else begin
                    expected_items = i_count;
                    next_upload    = 0;
                    receiving      = 1;
                    out.push_back(make_reply(K_REQ_INT, A_ACCEPTED, 0, 0, 0, 0, 0));
                end
            end
            CMD_UPLOAD: begin
                if (receiving) begin
                    if (i_seq != next_upload || s >= MAX_WAYPOINTS) begin
                        receiving = 0;
                        out.push_back(make_reply(K_ACK, A_BADSEQ, 0, 0, 0, 0, 0));
                    end else begin
                        lat_tab[s]  = i_lat_e7;
                        lon_tab[s]  = i_lon_e7;
                        alt_tab[s]  = i_alt_cm;
                        next_upload = 16'(i_seq + 16'd1);
                        if (next_upload < expected_items) begin
                            out.push_back(make_reply(i_legacy_form ? K_REQ_LEGACY
                                                                   : K_REQ_INT,
                                                     A_ACCEPTED, next_upload,
                                                     0, 0, 0, 0));
                        end else begin
                            stored_items = expected_items;
                            receiving    = 0;
                            out.push_back(make_reply(K_ACK, A_ACCEPTED, 0, 0, 0, 0, 1));
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                stored_items = 0;
                out.push_back(make_reply(K_ACK, A_ACCEPTED, 0, 0, 0, 0, 0));
            end
            default: ;
        endcase
        if (out.size() > 0)
            out[out.size() - 1].last = 1'b1;
        foreach (out[k])
            reply_q.push_back(out[k]);
    endtask

    // Compare one reply field by field against the oldest expectation
    task automatic compare_reply();
        t_reply e;
        t_reply a;
        a = '{o_reply_kind, o_ack_code, o_reply_number, o_reply_lat, o_reply_lon,
              o_reply_alt, o_upload_done, o_last};
        if (reply_q.size() == 0) begin
            $display("%0t: unexpected reply, actual %h", $realtime, a);
            o_fail_count++;
            return;
        end
        e = reply_q.pop_front();
        if (a.kind != e.kind || a.code != e.code || a.number != e.number ||
            a.lat != e.lat || a.lon != e.lon || a.alt != e.alt ||
            a.done != e.done || a.last != e.last) begin
            $display({"%0t: reply mismatch, expected kind %0d code %0d num %0d",
                      " lat %h lon %h alt %h done %b last %b"},
                     $realtime, e.kind, e.code, e.number, e.lat, e.lon, e.alt,
                     e.done, e.last);
            $display({"%0t:                 actual kind %0d code %0d num %0d",
                      " lat %h lon %h alt %h done %b last %b"},
                     $realtime, a.kind, a.code, a.number, a.lat, a.lon, a.alt,
                     a.done, a.last);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_reply_total = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            receiving      = 0;
            expected_items = 0;
            next_upload    = 0;
            stored_items   = 0;
        end else begin
            if (o_valid) begin
                compare_reply();
                o_reply_total++;
            end
            if (start && !busy)
                predict_word();
        end
    end
endmodule

// ===== test/mission_waypoint_transfer_test.sv =====
// Testbench top for the mission waypoint transfer block: stimulus and verdict.
`timescale 1ns / 1ps
module mission_waypoint_transfer_test import mwt_pkg::*;;
    localparam int MAXW      = 64;
    localparam int IDLE_MAX  = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_cmd;
    logic [15:0]        i_seq;
    logic [15:0]        i_count;
    logic signed [31:0] i_lat_e7;
    logic signed [31:0] i_lon_e7;
    logic signed [31:0] i_alt_cm;
    logic               i_legacy_form;
    logic               o_valid;
    logic [2:0]         o_reply_kind;
    logic [1:0]         o_ack_code;
    logic [15:0]        o_reply_number;
    logic signed [31:0] o_reply_lat;
    logic signed [31:0] o_reply_lon;
    logic signed [31:0] o_reply_alt;
    logic               o_upload_done;
    logic               o_last;
    int                 fail_count;
    int                 pending;
    int                 reply_total;
    int                 word_total;
    int                 idle_cycles;
    // Stored count as the testbench tracks it, to keep reads on written entries
    int                 tb_stored;
    int                 tb_expected;
    int                 tb_next;
    bit                 tb_receiving;

    mission_waypoint_transfer #(.MAX_WAYPOINTS(MAXW)) u_top (.*);

    mission_waypoint_transfer_check #(.MAX_WAYPOINTS(MAXW)) u_check (
        .*, .o_fail_count(fail_count), .o_pending(pending),
        .o_reply_total(reply_total)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: cycles with neither an accepted word nor a reply
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("%0t: watchdog expired", $realtime);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Random gap; start drops only when the gap is not empty
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
            start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Send one word; track shadow state so that reads can be aimed at written entries
    task automatic send_word(logic [2:0] cmd, logic [15:0] seq, logic [15:0] cnt,
                             logic [31:0] lat, logic [31:0] lon, logic [31:0] alt,
                             logic legacy);
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_seq         <= seq;
        i_count       <= cnt;
        i_lat_e7      <= lat;
        i_lon_e7      <= lon;
        i_alt_cm      <= alt;
        i_legacy_form <= legacy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        word_total++;
        case (cmd)
            CMD_START: begin
                if (cnt == 0) begin
                    tb_stored = 0;
                    tb_receiving = 0;
                end else if (cnt <= MAXW) begin
                    tb_expected = cnt;
                    tb_next = 0;
                    tb_receiving = 1;
                end
            end
            CMD_UPLOAD: begin
                if (tb_receiving) begin
                    if (seq != tb_next) begin
                        tb_receiving = 0;
                    end else begin
                        tb_next++;
                        if (tb_next >= tb_expected) begin
                            tb_stored = tb_expected;
                            tb_receiving = 0;
                        end
                    end
                end
            end
            CMD_CLEAR: tb_stored = 0;
            default: ;
        endcase
        idle_gap();
    endtask

    task automatic send_upload(int n, bit legacy_rand);
        send_word(CMD_START, 16'($urandom), 16'(n), $urandom, $urandom, $urandom,
                  1'($urandom));
        for (int k = 0; k < n; k++)
            send_word(CMD_UPLOAD, 16'(k), 16'($urandom), rand_coord(), rand_coord(),
                      rand_coord(), legacy_rand ? 1'($urandom) : 1'b0);
    endtask

    task automatic send_read(int s);
        send_word(CMD_READ, 16'(s), 16'($urandom), $urandom, $urandom, $urandom,
                  1'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    initial begin
        int r;
        int s;
        start = 0; i_cmd = 0; i_seq = 0; i_count = 0;
        i_lat_e7 = 0; i_lon_e7 = 0; i_alt_cm = 0; i_legacy_form = 0;
        i_rst_n = 0;
        idle_cycles = 0;
        word_total = 0;
        tb_stored = 0; tb_expected = 0; tb_next = 0; tb_receiving = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: every command, count and sequence edge cases
        send_word(CMD_LIST, 0, 0, 0, 0, 0, 0);
        send_word(CMD_UPLOAD, 0, 0, 1, 2, 3, 0);           // upload while idle
        send_word(CMD_START, 0, 16'hffff, 0, 0, 0, 0);     // count too large
        send_word(CMD_START, 0, 16'(MAXW + 1), 0, 0, 0, 0);
        send_word(CMD_START, 0, 0, 0, 0, 0, 0);            // empty upload
        send_word(CMD_START, 0, 3, 0, 0, 0, 0);
        send_word(CMD_UPLOAD, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1);
        send_word(CMD_UPLOAD, 1, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
        send_word(CMD_UPLOAD, 16'hffff, 0, 0, 0, 0, 1);    // wrong sequence
        send_upload(2, 1);
        send_read(0);
        send_read(1);                                       // final item
        send_read(16'hffff);
        send_word(CMD_LIST, 0, 0, 0, 0, 0, 0);
        send_word(CMD_START, 0, 2, 0, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);             // clear mid upload
        send_word(CMD_UPLOAD, 0, 0, 5, 6, 7, 1);
        send_word(CMD_UPLOAD, 1, 0, 8, 9, 10, 0);
        send_word(3'd5, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 16'hffff, 16'hffff, -1, -1, -1, 1);
        send_upload(MAXW, 1);
        send_read(MAXW - 1);
        wait_drained();                                      // sender holds off

        // Random: mostly well-formed uploads and reads, some noise
        while (word_total < 1100) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_upload(($urandom_range(0, 9) == 0) ? MAXW : $urandom_range(1, 6), 1);
            end else if (r < 60) begin
                if (tb_stored > 0 && !tb_receiving)
                    send_read($urandom_range(0, tb_stored - 1));
                else
                    send_read(tb_stored + $urandom_range(0, 3));
            end else if (r < 68) begin
                send_word(CMD_LIST, 16'($urandom), 16'($urandom), $urandom, $urandom,
                          $urandom, 1'($urandom));
            end else if (r < 74) begin
                send_word(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom, $urandom,
                          $urandom, 1'($urandom));
            end else if (r < 82) begin
                send_word(CMD_START, 16'($urandom), ($urandom_range(0, 1)) ? 16'($urandom)
                          : 16'($urandom_range(0, MAXW + 2)), $urandom, $urandom,
                          $urandom, 1'($urandom));
            end else if (r < 94) begin
                s = ($urandom_range(0, 1)) ? tb_next : int'($urandom);
                send_word(CMD_UPLOAD, 16'(s), 16'($urandom), rand_coord(), rand_coord(),
                          rand_coord(), 1'($urandom));
            end else begin
                send_word(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                          $urandom, $urandom, $urandom, 1'($urandom));
            end
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("Sent %0d words covering uploads, reads, clears and errors;", word_total);
        $display("checked %0d replies.", reply_total);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
